@@ design/rmt_pkg.sv @@
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared types and codes for the running mode tracker.
// ----------------------------------------------------------------------------
package rmt_pkg;

    localparam int ColorW    = 10;
    localparam int CountOutW = 10;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_REMOVE_EMPTY = 2'd1,
        STATUS_ADD_FULL     = 2'd2
    } status_t;

    // Operation after classification by the front end.
    typedef enum logic [1:0] {
        OP_NOP,
        OP_ADD,
        OP_REMOVE,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ColorW-1:0] color;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_CLEAR
    } back_state_t;

endpackage

@@ design/rmt_front.sv @@
// ----------------------------------------------------------------------------
// rmt_front
// Accepts command items and classifies them into queue entries.
// ----------------------------------------------------------------------------
module rmt_front
    import rmt_pkg::*;
#(
    parameter int NUM_COLORS = 1024
)
(
    input  logic              start,
    input  logic [1:0]        cmd,
    input  logic [ColorW-1:0] color,
    input  q_status_t         qs,
    input  logic              init_busy,
    output logic              busy,
    output logic              push,
    output item_t             item
);

    logic color_ok;

    assign busy     = qs.full | init_busy;
    assign push     = start & ~busy;
    assign color_ok = (color != '0) && (32'(color) < NUM_COLORS);

    always_comb
    begin
        item.color = color;
        case (cmd_t'(cmd))
            CMD_ADD:    item.op = color_ok ? OP_ADD : OP_NOP;
            CMD_REMOVE: item.op = color_ok ? OP_REMOVE : OP_NOP;
            CMD_CLEAR:  item.op = OP_CLEAR;
            default:    item.op = OP_NOP;
        endcase
    end

endmodule

@@ design/rmt_fifo.sv @@
// ----------------------------------------------------------------------------
// rmt_fifo
// Two-entry item queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
module rmt_fifo
    import rmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output q_status_t qs,
    output item_t     head
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign qs.full  = (cnt_reg == 2'd2);
    assign qs.empty = (cnt_reg == 2'd0);
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/rmt_back.sv @@
// ----------------------------------------------------------------------------
// rmt_back
// Execution engine: owns the count store, updates the mode and scans.
// ----------------------------------------------------------------------------
module rmt_back
    import rmt_pkg::*;
#(
    parameter int NUM_COLORS = 1024,
    parameter int MAX_COUNT  = 1023
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  q_status_t            qs,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 init_busy,
    output logic                 done,
    output logic [ColorW-1:0]    mode_color,
    output logic [CountOutW-1:0] mode_count,
    output logic [1:0]           status
);

    localparam int AW = $clog2(NUM_COLORS);
    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam logic [AW-1:0] LastAddr  = AW'(NUM_COLORS - 1);
    localparam logic [CW-1:0] MaxCnt    = CW'(MAX_COUNT);
    localparam logic [AW:0]   ScanLimit = (AW + 1)'(NUM_COLORS);

    logic [CW-1:0] mem [NUM_COLORS];

    back_state_t   state_reg, state_next;
    op_t           op_reg, op_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] mode_reg, mode_next;
    logic [CW-1:0] mode_cnt_reg, mode_cnt_next;
    status_t       status_reg, status_next;
    logic          done_reg, done_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW:0]   scan_reg, scan_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          found_reg, found_next;
    logic          found1_reg, found1_next;
    logic [AW-1:0] kt_reg, kt_next;
    logic [AW-1:0] kt1_reg, kt1_next;
    logic [CW-1:0] target_reg, target_next;
    logic [CW-1:0] rd_data_reg;

    logic          we;
    logic [AW-1:0] wa;
    logic [CW-1:0] wd;
    logic [AW-1:0] rd_addr;
    logic          clr_last;
    logic          scan_start;
    logic          scan_done;
    logic          hit_t;
    logic          hit_t1;
    logic [CW-1:0] t_inc;

    assign init_busy  = (state_reg == ST_INIT);
    assign done       = done_reg;
    assign mode_color = ColorW'(mode_reg);
    assign mode_count = CountOutW'(mode_cnt_reg);
    assign status     = status_reg;

    assign clr_last   = (clr_reg == LastAddr);
    assign t_inc      = rd_data_reg + CW'(1);
    assign scan_start = (op_reg == OP_REMOVE) && (rd_data_reg != '0)
                        && (addr_reg == mode_reg);
    assign scan_done  = pend_valid_reg && (pend_addr_reg == LastAddr);
    assign hit_t      = pend_valid_reg && (rd_data_reg == target_reg);
    // A colour one below the old count only counts while that level is not zero.
    assign hit_t1     = pend_valid_reg && (target_reg != CW'(1))
                        && (rd_data_reg == target_reg - CW'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!qs.empty)
                begin
                    case (q_item.op)
                        OP_NOP:   state_next = ST_IDLE;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_LOOK;
                    endcase
                end
            end
            ST_LOOK:  state_next = scan_start ? ST_SCAN : ST_IDLE;
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        addr_next       = addr_reg;
        mode_next       = mode_reg;
        mode_cnt_next   = mode_cnt_reg;
        status_next     = status_reg;
        done_next       = 1'b0;
        clr_next        = clr_reg;
        scan_next       = scan_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        found_next      = found_reg;
        found1_next     = found1_reg;
        kt_next         = kt_reg;
        kt1_next        = kt1_reg;
        target_next     = target_reg;
        we              = 1'b0;
        wa              = addr_reg;
        wd              = '0;
        rd_addr         = addr_reg;
        q_pop           = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                clr_next = clr_last ? '0 : clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (!qs.empty)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_item.op;
                    addr_next = AW'(q_item.color);
                    rd_addr   = AW'(q_item.color);
                    clr_next  = '0;
                    if (q_item.op == OP_NOP)
                    begin
                        status_next = STATUS_OK;
                        done_next   = 1'b1;
                    end
                end
            end
            ST_LOOK:
            begin
                done_next   = 1'b1;
                status_next = STATUS_OK;
                if (op_reg == OP_ADD)
                begin
                    if (rd_data_reg == MaxCnt)
                    begin
                        status_next = STATUS_ADD_FULL;
                    end
                    else
                    begin
                        we = 1'b1;
                        wd = t_inc;
                        if ((t_inc > mode_cnt_reg) ||
                            ((t_inc == mode_cnt_reg) && (addr_reg < mode_reg)))
                        begin
                            mode_next     = addr_reg;
                            mode_cnt_next = t_inc;
                        end
                    end
                end
                else
                begin
                    if (rd_data_reg == '0)
                    begin
                        status_next = STATUS_REMOVE_EMPTY;
                    end
                    else
                    begin
                        we = 1'b1;
                        wd = rd_data_reg - CW'(1);
                        if (scan_start)
                        begin
                            done_next   = 1'b0;
                            target_next = rd_data_reg;
                            scan_next   = (AW + 1)'(1);
                            found_next  = 1'b0;
                            found1_next = 1'b0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // One read issued per cycle; its registered data is checked in the next cycle.
                rd_addr         = scan_reg[AW-1:0];
                pend_valid_next = (scan_reg < ScanLimit);
                pend_addr_next  = scan_reg[AW-1:0];
                if (scan_reg < ScanLimit)
                    scan_next = scan_reg + (AW + 1)'(1);
                if (hit_t && !found_reg)
                begin
                    found_next = 1'b1;
                    kt_next    = pend_addr_reg;
                end
                if (hit_t1 && !found1_reg)
                begin
                    found1_next = 1'b1;
                    kt1_next    = pend_addr_reg;
                end
                if (scan_done)
                begin
                    done_next       = 1'b1;
                    status_next     = STATUS_OK;
                    pend_valid_next = 1'b0;
                    if (found_next)
                    begin
                        mode_next     = kt_next;
                        mode_cnt_next = target_reg;
                    end
                    else if (found1_next)
                    begin
                        mode_next     = kt1_next;
                        mode_cnt_next = target_reg - CW'(1);
                    end
                    else
                    begin
                        mode_next     = '0;
                        mode_cnt_next = '0;
                    end
                end
            end
            ST_CLEAR:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                clr_next = clr_last ? '0 : clr_reg + AW'(1);
                if (clr_last)
                begin
                    mode_next     = '0;
                    mode_cnt_next = '0;
                    status_next   = STATUS_OK;
                    done_next     = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            op_reg         <= OP_NOP;
            mode_reg       <= '0;
            mode_cnt_reg   <= '0;
            status_reg     <= STATUS_OK;
            done_reg       <= 1'b0;
            clr_reg        <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            found1_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            mode_reg       <= mode_next;
            mode_cnt_reg   <= mode_cnt_next;
            status_reg     <= status_next;
            done_reg       <= done_next;
            clr_reg        <= clr_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            found1_reg     <= found1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        pend_addr_reg <= pend_addr_next;
        kt_reg        <= kt_next;
        kt1_reg       <= kt1_next;
        target_reg    <= target_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

@@ design/running_mode_tracker_top.sv @@
// ----------------------------------------------------------------------------
// running_mode_tracker_top
// Tracks per-colour occurrence counts and the current mode colour.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. cmd adds or removes
// one occurrence of color, or clears all counts. For each item exactly one
// result appears: done is high for one cycle while mode_color, mode_count
// and status hold the values after the update. The receiver cannot stall;
// the result is taken in the cycle that done marks.
// A front end classifies items into a two-entry queue, so start may be
// accepted while the engine still works; outside the clear after reset,
// busy rises only when the queue is full. For an add or a remove, the engine
// reads the count in its idle state and writes the update in its look state;
// an unused command or a colour of zero is answered from the idle state.
// Removing the mode colour scans the whole count store through its single
// read port. A clear writes every entry once.
// After reset the count store is cleared; busy stays high meanwhile and no
// item is accepted.
// ----------------------------------------------------------------------------
module running_mode_tracker_top
    import rmt_pkg::*;
#(
    parameter int NUM_COLORS = 1024,
    parameter int MAX_COUNT  = 1023
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           cmd,
    input  logic [ColorW-1:0]    color,
    output logic                 busy,
    output logic                 done,
    output logic [ColorW-1:0]    mode_color,
    output logic [CountOutW-1:0] mode_count,
    output logic [1:0]           status
);

    q_status_t qs;
    item_t     push_item;
    item_t     head;
    logic      push;
    logic      pop;
    logic      init_busy;

    rmt_front #(
        .NUM_COLORS(NUM_COLORS)
    ) u_front (
        .start    (start),
        .cmd      (cmd),
        .color    (color),
        .qs       (qs),
        .init_busy(init_busy),
        .busy     (busy),
        .push     (push),
        .item     (push_item)
    );

    rmt_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .qs       (qs),
        .head     (head)
    );

    rmt_back #(
        .NUM_COLORS(NUM_COLORS),
        .MAX_COUNT (MAX_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qs        (qs),
        .q_item    (head),
        .q_pop     (pop),
        .init_busy (init_busy),
        .done      (done),
        .mode_color(mode_color),
        .mode_count(mode_count),
        .status    (status)
    );

endmodule

@@ design/rmt_checker.sv @@
// ----------------------------------------------------------------------------
// rmt_checker
// Port-level checks on the results of the running mode tracker.
// ----------------------------------------------------------------------------
module rmt_checker
    import rmt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 done,
    input logic [ColorW-1:0]    mode_color,
    input logic [CountOutW-1:0] mode_count,
    input logic [1:0]           status
);

    // Only the three defined status codes may appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_OK || status == STATUS_REMOVE_EMPTY ||
                  status == STATUS_ADD_FULL))
        else $error("undefined status code");

    // An empty tracker reports a zero count.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_color == '0) |-> (mode_count == '0))
        else $error("nonzero count with no mode");

    // A colour at the maximum count exists, so there is a mode.
    a_full_has_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_ADD_FULL) |-> (mode_color != '0))
        else $error("add at maximum reported with no mode");

endmodule

bind running_mode_tracker_top rmt_checker u_rmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .done      (done),
    .mode_color(mode_color),
    .mode_count(mode_count),
    .status    (status)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for running_mode_tracker_top
// Drives add, remove and clear items through the start/busy handshake and
// checks every result strobe against a cycle-free model of the count store,
// the per-count buckets and the mode colour.
// ----------------------------------------------------------------------------
module tb;
    import rmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NColors   = 1024;
    localparam int MaxCount  = 1023;
    localparam int CycleLimit = 10000000;

    typedef struct packed {
        logic [ColorW-1:0]    mode_color;
        logic [CountOutW-1:0] mode_count;
        logic [1:0]           status;
    } mode_result_t;

    typedef struct {
        logic [1:0]        cmd;
        logic [ColorW-1:0] color;
        logic              has_exp;
        mode_result_t      exp;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic [1:0]           cmd;
    logic [ColorW-1:0]    color;
    logic                 busy;
    logic                 done;
    logic [ColorW-1:0]    mode_color;
    logic [CountOutW-1:0] mode_count;
    logic [1:0]           status;

    int unsigned   occ_count [NColors];
    int unsigned   bucket_size [MaxCount+1];
    int unsigned   cur_mode;
    mode_result_t  pending_modes [$];
    int            mismatches;
    int            cycles;
    stim_row_t     directed [$];

    running_mode_tracker_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .color      (color),
        .busy       (busy),
        .done       (done),
        .mode_color (mode_color),
        .mode_count (mode_count),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_counts();
        foreach (occ_count[i]) occ_count[i] = 0;
        foreach (bucket_size[i]) bucket_size[i] = 0;
        bucket_size[0] = NColors;
        cur_mode = 0;
    endfunction

    function automatic int unsigned smallest_at(int unsigned target);
        if (target == 0)
            return 0;
        for (int k = 1; k < NColors; k++)
            if (occ_count[k] == target)
                return k;
        return 0;
    endfunction

    function automatic mode_result_t update_mode(logic [1:0] c, logic [ColorW-1:0] col);
        mode_result_t r;
        int unsigned  t;
        int unsigned  mc;
        r.status = STATUS_OK;
        if (c == CMD_CLEAR)
            clear_counts();
        else if ((c == CMD_ADD || c == CMD_REMOVE) && col != 0)
        begin
            t = occ_count[col];
            if (c == CMD_ADD)
            begin
                if (t >= MaxCount)
                    r.status = STATUS_ADD_FULL;
                else
                begin
                    occ_count[col] = t + 1;
                    bucket_size[t]--;
                    bucket_size[t+1]++;
                    mc = occ_count[cur_mode];
                    if (t + 1 > mc || (t + 1 == mc && col < cur_mode))
                        cur_mode = 32'(col);
                end
            end
            else if (t == 0)
                r.status = STATUS_REMOVE_EMPTY;
            else
            begin
                occ_count[col] = t - 1;
                bucket_size[t]--;
                bucket_size[t-1]++;
                if (col == cur_mode)
                    cur_mode = (bucket_size[t] != 0) ? smallest_at(t) : smallest_at(t - 1);
            end
        end
        r.mode_color = ColorW'(cur_mode);
        r.mode_count = (cur_mode != 0) ? CountOutW'(occ_count[cur_mode]) : '0;
        return r;
    endfunction

    // Result monitor.
    always @(posedge clk)
    begin
        mode_result_t e;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (pending_modes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: color %0d count %0d status %0d",
                             mode_color, mode_count, status);
            end
            else
            begin
                e = pending_modes.pop_front();
                if (e.mode_color !== mode_color || e.mode_count !== mode_count
                    || e.status !== status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp color %0d count %0d status %0d, got %0d %0d %0d",
                                 e.mode_color, e.mode_count, e.status,
                                 mode_color, mode_count, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CycleLimit)
        begin
            $display("running_mode_tracker_top test failed");
            $finish;
        end
    end

    // Presents one item and holds it until the handshake takes it.
    task automatic send_item(logic [1:0] c, logic [ColorW-1:0] col,
                             logic has_exp, mode_result_t exp);
        mode_result_t p;
        start <= 1'b1;
        cmd   <= c;
        color <= col;
        do
            @(posedge clk);
        while (busy);
        p = update_mode(c, col);
        if (has_exp && (p != exp))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with prediction for cmd %0d color %0d", c, col);
        end
        pending_modes.push_back(has_exp ? exp : p);
        @(negedge clk);
    endtask

    task automatic idle_gap(bit allow);
        if (allow && $urandom_range(99) < 15)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    function automatic void add_row(logic [1:0] c, logic [ColorW-1:0] col, logic h,
                                    logic [ColorW-1:0] ec, logic [CountOutW-1:0] en,
                                    logic [1:0] es);
        stim_row_t r;
        r.cmd = c;
        r.color = col;
        r.has_exp = h;
        r.exp.mode_color = ec;
        r.exp.mode_count = en;
        r.exp.status = es;
        directed.push_back(r);
    endfunction

    initial
    begin
        logic [1:0]        c;
        logic [ColorW-1:0] col;
        int unsigned       pick;
        mode_result_t      none;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = CMD_ADD;
        color = '0;
        mismatches = 0;
        cycles = 0;
        none = '0;
        clear_counts();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(CMD_REMOVE, 10'd5, 1, 10'd0, 10'd0, STATUS_REMOVE_EMPTY);
        add_row(CMD_ADD, 10'd0, 1, 10'd0, 10'd0, STATUS_OK);
        add_row(CMD_ADD, 10'd1023, 1, 10'd1023, 10'd1, STATUS_OK);
        add_row(CMD_ADD, 10'd1, 1, 10'd1, 10'd1, STATUS_OK);
        add_row(2'd3, 10'd1, 1, 10'd1, 10'd1, STATUS_OK);
        add_row(CMD_ADD, 10'd1023, 1, 10'd1023, 10'd2, STATUS_OK);
        add_row(CMD_ADD, 10'd682, 0, 0, 0, 0);
        add_row(CMD_ADD, 10'd341, 0, 0, 0, 0);
        add_row(CMD_ADD, 10'd341, 0, 0, 0, 0);
        add_row(CMD_REMOVE, 10'd341, 0, 0, 0, 0);
        add_row(CMD_REMOVE, 10'd341, 0, 0, 0, 0);
        add_row(CMD_REMOVE, 10'd1023, 0, 0, 0, 0);
        add_row(CMD_REMOVE, 10'd1, 0, 0, 0, 0);
        add_row(CMD_REMOVE, 10'd0, 0, 0, 0, 0);
        add_row(CMD_REMOVE, 10'd682, 0, 0, 0, 0);
        add_row(CMD_REMOVE, 10'd1023, 1, 10'd0, 10'd0, STATUS_OK);
        add_row(CMD_CLEAR, 10'd1023, 1, 10'd0, 10'd0, STATUS_OK);
        foreach (directed[i])
            send_item(directed[i].cmd, directed[i].color, directed[i].has_exp,
                      directed[i].exp);

        // Drive one colour up to the count limit; the last add must be refused.
        for (int i = 0; i <= MaxCount; i++)
            send_item(CMD_ADD, 10'd2, 0, none);
        send_item(CMD_ADD, 10'd3, 0, none);
        send_item(CMD_REMOVE, 10'd2, 0, none);
        send_item(CMD_CLEAR, 10'd0, 0, none);

        // Hold off until every result is in.
        start <= 1'b0;
        while (pending_modes.size() != 0)
            @(negedge clk);

        // Small colour pool so counts build up and modes tie and get removed.
        for (int n = 0; n < 580; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                c = CMD_ADD;
            else if (pick < 93)
                c = CMD_REMOVE;
            else if (pick < 95)
                c = CMD_CLEAR;
            else
                c = 2'd3;
            if ($urandom_range(9) < 8)
                col = ColorW'($urandom_range(1, 6) * ($urandom_range(1) ? 1 : 170));
            else
                col = ColorW'($urandom);
            send_item(c, col, 0, none);
            idle_gap(n < 200 || n >= 350);
        end
        start <= 1'b0;

        while (pending_modes.size() != 0)
            @(negedge clk);
        repeat (2 * NColors + 20) @(negedge clk);
        if (mismatches == 0 && pending_modes.size() == 0)
            $display("running_mode_tracker_top test passed");
        else
            $display("running_mode_tracker_top test failed");
        $finish;
    end
endmodule
